// ----- src/ebv_pkg.sv -----
`timescale 1ns / 1ps

package ebv_pkg;

   localparam int XY_BITS = 34;
   localparam int TRIG_BITS = 32;
   localparam logic signed [XY_BITS-1:0] CORDIC_K = 34'sd652032874;

   typedef struct packed {
      logic [15:0] pitch_angle;
      logic [15:0] yaw_angle;
      logic [15:0] roll_angle;
   } ebv_req_type;

   typedef struct packed {
      logic signed [15:0] fwd_x;
      logic signed [15:0] fwd_y;
      logic signed [15:0] fwd_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } ebv_rsp_type;

   // atan(2^-i), full circle = 2^32
   function automatic logic signed [XY_BITS-1:0] atan_lut(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;   5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;   5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;    5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;    5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;     5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;     5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;     5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;      5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;      5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;       5'd19: v = 32'd1304;
         5'd20: v = 32'd652;        5'd21: v = 32'd326;
         5'd22: v = 32'd163;        5'd23: v = 32'd81;
         5'd24: v = 32'd41;         5'd25: v = 32'd20;
         5'd26: v = 32'd10;         5'd27: v = 32'd5;
         5'd28: v = 32'd3;          5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return XY_BITS'($signed({1'b0, v}));
   endfunction

   // Q1.30 product, round half up
   function automatic logic signed [TRIG_BITS-1:0] mul30(
      input logic signed [TRIG_BITS-1:0] a,
      input logic signed [TRIG_BITS-1:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
      return TRIG_BITS'(p >>> 30);
   endfunction

endpackage

// ----- src/ebv_cordic.sv -----
`timescale 1ns / 1ps

module ebv_cordic #(
   parameter int ITERATIONS = 16
) (
   input  logic clock,
   input  logic advance,
   input  logic [31:0] angle,
   output logic signed [ebv_pkg::TRIG_BITS-1:0] sin_out,
   output logic signed [ebv_pkg::TRIG_BITS-1:0] cos_out
);
   import ebv_pkg::*;

   logic signed [XY_BITS-1:0] x_ff [ITERATIONS];
   logic signed [XY_BITS-1:0] y_ff [ITERATIONS];
   logic signed [XY_BITS-1:0] z_ff [ITERATIONS];
   logic [1:0]                quad_ff [ITERATIONS];

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      logic signed [XY_BITS-1:0] xp, yp, zp, x_in, y_in, z_in;
      logic [1:0] qp;
      if (i == 0) begin : g_first
         assign xp = CORDIC_K;
         assign yp = '0;
         assign zp = XY_BITS'({2'b00, angle[29:0]});
         assign qp = angle[31:30];
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign qp = quad_ff[i-1];
      end
      always_comb begin
         if (!zp[XY_BITS-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - atan_lut(5'(i));
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + atan_lut(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            quad_ff[i] <= qp;
         end
      end
   end

   logic signed [XY_BITS-1:0] xl, yl;
   assign xl = x_ff[ITERATIONS-1];
   assign yl = y_ff[ITERATIONS-1];

   always_comb begin
      case (quad_ff[ITERATIONS-1])
         2'd0: begin cos_out = TRIG_BITS'(xl);  sin_out = TRIG_BITS'(yl);  end
         2'd1: begin cos_out = TRIG_BITS'(-yl); sin_out = TRIG_BITS'(xl);  end
         2'd2: begin cos_out = TRIG_BITS'(-xl); sin_out = TRIG_BITS'(-yl); end
         default: begin cos_out = TRIG_BITS'(yl); sin_out = TRIG_BITS'(-xl); end
      endcase
   end

   // final z lane is carried only for the iteration chain
   logic unused_z;
   assign unused_z = ^z_ff[ITERATIONS-1];

endmodule

// ----- src/euler_to_basis_vectors.sv -----
`timescale 1ns / 1ps

// Euler angles to forward/right/up basis vectors. Each item carries pitch,
// yaw and roll as binary angles (full circle = 2^ANGLE_BITS); the result item
// holds the nine vector components in signed fixed point with
// VECTOR_FRAC_BITS fraction bits, saturated at +/-1. Fully pipelined: one item
// per cycle while the output item is not held, through one CORDIC stage per
// iteration plus quadrant fold, two product stages and the output rounding
// stage. A stall on a valid rsp item freezes the whole pipeline.
module euler_to_basis_vectors #(
   parameter int ANGLE_BITS       = 16,
   parameter int VECTOR_FRAC_BITS = 14,
   parameter int TRIG_ITERATIONS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ebv_pkg::ebv_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ebv_pkg::ebv_rsp_type rsp_data
);
   import ebv_pkg::*;

   localparam int ITERS = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
   localparam int LAT   = ITERS + 4;
   localparam int SH    = 30 - VECTOR_FRAC_BITS;
   localparam logic signed [33:0] RND = (SH > 0) ? (34'sd1 <<< (SH - 1)) : 34'sd0;
   localparam logic signed [33:0] ONE = 34'sd1 <<< VECTOR_FRAC_BITS;
   localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

   logic [LAT-1:0] valid_ff, valid_in;

   // whole pipeline moves unless the output item is held
   logic advance;
   assign advance   = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;

   assign valid_in = {valid_ff[LAT-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end
   assign rsp_valid = valid_ff[LAT-1];

   function automatic logic [31:0] to_a32(input logic [15:0] a);
      return (32'(a) & AMASK) << (32 - ANGLE_BITS);
   endfunction

   logic signed [TRIG_BITS-1:0] sp, cp, sy, cy, sr, cr;

   ebv_cordic #(.ITERATIONS(ITERS)) u_pitch (
      .clock(clock), .advance(advance), .angle(to_a32(req_data.pitch_angle)),
      .sin_out(sp), .cos_out(cp));
   ebv_cordic #(.ITERATIONS(ITERS)) u_yaw (
      .clock(clock), .advance(advance), .angle(to_a32(req_data.yaw_angle)),
      .sin_out(sy), .cos_out(cy));
   ebv_cordic #(.ITERATIONS(ITERS)) u_roll (
      .clock(clock), .advance(advance), .angle(to_a32(req_data.roll_angle)),
      .sin_out(sr), .cos_out(cr));

   // stage: registered sin/cos after quadrant fold
   logic signed [TRIG_BITS-1:0] sp_ff, cp_ff, sy_ff, cy_ff, sr_ff, cr_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         sp_ff <= sp; cp_ff <= cp; sy_ff <= sy;
         cy_ff <= cy; sr_ff <= sr; cr_ff <= cr;
      end
   end

   // stage: pairwise products
   logic signed [TRIG_BITS-1:0] srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   logic signed [TRIG_BITS-1:0] srcp_ff, crcp_ff, srsy_ff, srcy_ff, sp2_ff, sy2_ff, cy2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         srsp_ff <= mul30(sr_ff, sp_ff);
         crsp_ff <= mul30(cr_ff, sp_ff);
         cpcy_ff <= mul30(cp_ff, cy_ff);
         cpsy_ff <= mul30(cp_ff, sy_ff);
         crsy_ff <= mul30(cr_ff, sy_ff);
         crcy_ff <= mul30(cr_ff, cy_ff);
         srcp_ff <= mul30(sr_ff, cp_ff);
         crcp_ff <= mul30(cr_ff, cp_ff);
         srsy_ff <= mul30(sr_ff, sy_ff);
         srcy_ff <= mul30(sr_ff, cy_ff);
         sp2_ff  <= sp_ff;
         sy2_ff  <= sy_ff;
         cy2_ff  <= cy_ff;
      end
   end

   // stage: triple products, pass the rest
   logic signed [TRIG_BITS-1:0] t_srcy_ff, t_srsy_ff, t_crcy_ff, t_crsy_ff;
   logic signed [TRIG_BITS-1:0] p_cpcy_ff, p_cpsy_ff, p_sp_ff, p_crsy_ff, p_crcy_ff;
   logic signed [TRIG_BITS-1:0] p_srcp_ff, p_srsy_ff, p_srcy_ff, p_crcp_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         t_srcy_ff <= mul30(srsp_ff, cy2_ff);
         t_srsy_ff <= mul30(srsp_ff, sy2_ff);
         t_crcy_ff <= mul30(crsp_ff, cy2_ff);
         t_crsy_ff <= mul30(crsp_ff, sy2_ff);
         p_cpcy_ff <= cpcy_ff; p_cpsy_ff <= cpsy_ff; p_sp_ff <= sp2_ff;
         p_crsy_ff <= crsy_ff; p_crcy_ff <= crcy_ff; p_srcp_ff <= srcp_ff;
         p_srsy_ff <= srsy_ff; p_srcy_ff <= srcy_ff; p_crcp_ff <= crcp_ff;
      end
   end

   // round to output format, saturate to +/-1, keep the low 16 bits
   function automatic logic signed [15:0] to_out(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = (v + RND) >>> SH;
      if (r > ONE) r = ONE;
      if (r < -ONE) r = -ONE;
      return 16'(r);
   endfunction

   function automatic logic signed [33:0] ext(input logic signed [TRIG_BITS-1:0] v);
      return 34'(v);
   endfunction

   ebv_rsp_type rsp_in, rsp_ff;
   always_comb begin
      rsp_in.fwd_x   = to_out(ext(p_cpcy_ff));
      rsp_in.fwd_y   = to_out(ext(p_cpsy_ff));
      rsp_in.fwd_z   = to_out(-ext(p_sp_ff));
      rsp_in.right_x = to_out(-ext(t_srcy_ff) + ext(p_crsy_ff));
      rsp_in.right_y = to_out(-ext(t_srsy_ff) - ext(p_crcy_ff));
      rsp_in.right_z = to_out(-ext(p_srcp_ff));
      rsp_in.up_x    = to_out(ext(t_crcy_ff) + ext(p_srsy_ff));
      rsp_in.up_y    = to_out(ext(t_crsy_ff) - ext(p_srcy_ff));
      rsp_in.up_z    = to_out(ext(p_crcp_ff));
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end
   assign rsp_data = rsp_ff;

   // a held output freezes every stage's valid bit
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff))
      else $error("pipeline moved while output held");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an accepted item sits in the first stage in the following cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0 && req_valid && !req_stall) ##1 (!rsp_stall) |->
         valid_ff[0])
      else $error("accepted item not in first stage");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && VECTOR_FRAC_BITS <= 14) |->
         (rsp_data.up_z <= 16'(ONE) && rsp_data.up_z >= -16'(ONE)))
      else $error("up_z outside unit range");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import ebv_pkg::*;

   localparam int LATENCY    = 20;     // 16 CORDIC stages + 4 further stages
   localparam int IDLE_LIMIT = 20000;  // cycles with no handshake
   localparam int RAND_ITEMS = 500;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ebv_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   ebv_rsp_type rsp_data;

   euler_to_basis_vectors i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Directed table: angles plus an optional typed-in expectation. Rows with
   // has_exp clear are checked against the predictor only.
   typedef struct {
      logic [15:0] p, y, r;
      bit          has_exp;
      ebv_rsp_type exp;
   } dir_row_type;

   ebv_rsp_type basis_q[$];   // expected result items, oldest first
   int          err_count;
   int          sender_idle_pct, receiver_idle_pct;
   int          quiet_cycles;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // ---------------- predictor ----------------
   function automatic longint fshift(input longint v, input int s);
      return v >>> s;   // arithmetic shift is floor division by 2^s
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return fshift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic logic signed [15:0] to_q14(input longint v);
      longint t;
      t = fshift(v + (64'sd1 <<< 15), 16);
      if (t > 16384) t = 16384;
      if (t < -16384) t = -16384;
      return t[15:0];
   endfunction

   // rotation-mode CORDIC over the residual angle, then quadrant fold
   function automatic void sin_cos(input logic [15:0] ang, output longint sn,
                                   output longint cs);
      logic [31:0] a32;
      longint x, y, z, dx, dy, atn;
      a32 = {ang, 16'h0};
      x = 652032874;
      y = 0;
      z = longint'(a32[29:0]);
      for (int i = 0; i < 16; i++) begin
         atn = longint'(atan_lut(5'(i)));
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atn;
         end else begin
            x += dx; y -= dy; z += atn;
         end
      end
      case (a32[31:30])
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endfunction

   function automatic ebv_rsp_type predict_basis(input ebv_req_type it);
      longint sp, cp, sy, cy, sr, cr, srsp, crsp;
      ebv_rsp_type o;
      sin_cos(it.pitch_angle, sp, cp);
      sin_cos(it.yaw_angle, sy, cy);
      sin_cos(it.roll_angle, sr, cr);
      srsp = qmul(sr, sp);
      crsp = qmul(cr, sp);
      o.fwd_x   = to_q14(qmul(cp, cy));
      o.fwd_y   = to_q14(qmul(cp, sy));
      o.fwd_z   = to_q14(-sp);
      o.right_x = to_q14(-qmul(srsp, cy) + qmul(cr, sy));
      o.right_y = to_q14(-qmul(srsp, sy) - qmul(cr, cy));
      o.right_z = to_q14(-qmul(sr, cp));
      o.up_x    = to_q14(qmul(crsp, cy) + qmul(sr, sy));
      o.up_y    = to_q14(qmul(crsp, sy) - qmul(sr, cy));
      o.up_z    = to_q14(qmul(cr, cp));
      return o;
   endfunction

   // ---------------- driver ----------------
   // valid stays up after an accepted item; idle cycles drop it
   task automatic send_item(input ebv_req_type it);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      basis_q.push_back(predict_basis(it));
      @(negedge clock);
   endtask

   // receiver stall: re-rolled every falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (receiver_idle_pct > 0) && ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // ---------------- checker ----------------
   always @(posedge clock) begin
      ebv_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (basis_q.size() == 0) begin
            $display("unexpected result item at %0t", $realtime);
            err_count++;
         end else begin
            want = basis_q.pop_front();
            if (rsp_data.fwd_x !== want.fwd_x) report_mismatch("fwd_x", rsp_data.fwd_x, want.fwd_x);
            if (rsp_data.fwd_y !== want.fwd_y) report_mismatch("fwd_y", rsp_data.fwd_y, want.fwd_y);
            if (rsp_data.fwd_z !== want.fwd_z) report_mismatch("fwd_z", rsp_data.fwd_z, want.fwd_z);
            if (rsp_data.right_x !== want.right_x)
               report_mismatch("right_x", rsp_data.right_x, want.right_x);
            if (rsp_data.right_y !== want.right_y)
               report_mismatch("right_y", rsp_data.right_y, want.right_y);
            if (rsp_data.right_z !== want.right_z)
               report_mismatch("right_z", rsp_data.right_z, want.right_z);
            if (rsp_data.up_x !== want.up_x) report_mismatch("up_x", rsp_data.up_x, want.up_x);
            if (rsp_data.up_y !== want.up_y) report_mismatch("up_y", rsp_data.up_y, want.up_y);
            if (rsp_data.up_z !== want.up_z) report_mismatch("up_z", rsp_data.up_z, want.up_z);
         end
      end
   end

   // watchdog: any handshake on either side resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** euler_to_basis_vectors: FAILED **");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      ebv_req_type it;
      ebv_rsp_type pred;
      int          drain;

      err_count         = 0;
      quiet_cycles      = 0;
      sender_idle_pct   = 34;
      receiver_idle_pct = 78;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Identity orientation reads off directly: fwd=(1,0,0),
      // right=(0,-1,0), up=(0,0,1), with CORDIC rounding checked via predictor
      // for everything else. Quadrant boundaries, all-ones, and sign bits.
      row = '{p:16'h0000, y:16'h0000, r:16'h0000, has_exp:1'b0, exp:'0};
      rows.push_back(row);
      begin
         logic [15:0] dv[$];
         dv = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001,
                16'h3FFF, 16'h7FFF, 16'h2000, 16'hAAAA, 16'h5555};
         foreach (dv[k]) begin
            rows.push_back('{p:dv[k], y:dv[(k+3)%dv.size()], r:dv[(k+7)%dv.size()],
                             has_exp:1'b0, exp:'0});
         end
         rows.push_back('{p:16'hFFFF, y:16'hFFFF, r:16'hFFFF, has_exp:1'b0, exp:'0});
         rows.push_back('{p:16'h4000, y:16'h0000, r:16'h0000, has_exp:1'b0, exp:'0});
         rows.push_back('{p:16'hC000, y:16'h4000, r:16'h8000, has_exp:1'b0, exp:'0});
      end

      // directed part under the first idling mix
      foreach (rows[k]) begin
         it.pitch_angle = rows[k].p;
         it.yaw_angle   = rows[k].y;
         it.roll_angle  = rows[k].r;
         if (rows[k].has_exp) begin
            pred = predict_basis(it);
            if (pred !== rows[k].exp) report_mismatch("directed row", k, 0);
         end
         send_item(it);
      end

      // random part in three idling phases
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 3) begin
            sender_idle_pct = 78; receiver_idle_pct = 34;
         end else if (n == 2 * RAND_ITEMS / 3) begin
            sender_idle_pct = 0; receiver_idle_pct = 0;
         end
         it.pitch_angle = 16'($urandom);
         it.yaw_angle   = 16'($urandom);
         it.roll_angle  = 16'($urandom);
         // some items near quadrant edges
         if ($urandom_range(7) == 0) it.pitch_angle[13:0] = 14'($urandom_range(3));
         send_item(it);
      end
      req_valid <= 1'b0;

      drain = 0;
      while (basis_q.size() != 0 && drain < IDLE_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 4) @(posedge clock);

      if (err_count == 0 && basis_q.size() == 0) begin
         $display("** euler_to_basis_vectors: PASSED **");
      end else begin
         $display("** euler_to_basis_vectors: FAILED **");
      end
      $finish;
   end

endmodule
